>>> hdl/mbox_pkg.sv
`timescale 1ns / 1ps

package mbox_pkg;

	// Positions of the From_ date pattern matcher.
	localparam int NFA_POS = 61;
	localparam int ACC_A = 36;
	localparam int ACC_B = 60;
	localparam int NFA_FANOUT = 4;

	// Widths fixed by the fields and registers.
	localparam int TARGET_BITS = 24;
	localparam int MIB_BITS = 12;
	localparam int MIB_SHIFT = 20;
	localparam int BYTES_BITS = 33;
	localparam int CFG_DATA_BITS = 24;
	localparam int CFG_INDEX_BITS = 2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_QUIRK = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_MIB = 2'd2;
	localparam logic [MIB_BITS-1:0] MAX_MIB_RESET = 12'd100;

	// Result kinds.
	localparam logic [1:0] KIND_BODY = 2'd0;
	localparam logic [1:0] KIND_SEP = 2'd1;
	localparam logic [1:0] KIND_EOF = 2'd2;

	// Bytes of interest.
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	// Progress through a bare "From " line.
	localparam logic [2:0] SHORT_DONE = 3'd5;
	localparam logic [2:0] SHORT_FAIL = 3'd6;

	typedef enum logic [4:0] {
		CL_NONE, CL_F, CL_R, CL_O, CL_M, CL_SP, CL_NSP, CL_DQ, CL_NDQ, CL_AL,
		CL_D03S, CL_DIG, CL_D02, CL_COLON, CL_D05, CL_D12, CL_D03, CL_COMMA
	} char_class_t;

	typedef logic [NFA_POS-1:0] nfa_vec_t;

	localparam char_class_t POS_CLASS [NFA_POS] = '{
		CL_NONE, CL_F, CL_R, CL_O, CL_M, CL_SP, CL_NSP, CL_DQ, CL_NDQ, CL_DQ,
		CL_SP, CL_AL, CL_AL, CL_AL, CL_SP, CL_AL, CL_AL, CL_AL, CL_SP, CL_D03S,
		CL_DIG, CL_SP, CL_D02, CL_DIG, CL_COLON, CL_D05, CL_DIG, CL_COLON, CL_D05, CL_DIG,
		CL_SP, CL_NSP, CL_SP, CL_D12, CL_DIG, CL_DIG, CL_DIG, CL_NSP, CL_SP, CL_AL,
		CL_AL, CL_AL, CL_COMMA, CL_SP, CL_D03, CL_DIG, CL_SP, CL_AL, CL_AL, CL_AL,
		CL_SP, CL_D12, CL_DIG, CL_DIG, CL_DIG, CL_SP, CL_D02, CL_DIG, CL_COLON, CL_D05,
		CL_DIG
	};

	// Successors of each position; zero marks an unused slot.
	localparam logic [5:0] POS_NEXT [NFA_POS][NFA_FANOUT] = '{
		'{6'd1, 6'd0, 6'd0, 6'd0}, '{6'd2, 6'd0, 6'd0, 6'd0},
		'{6'd3, 6'd0, 6'd0, 6'd0}, '{6'd4, 6'd0, 6'd0, 6'd0},
		'{6'd5, 6'd0, 6'd0, 6'd0}, '{6'd5, 6'd6, 6'd7, 6'd37},
		'{6'd6, 6'd10, 6'd0, 6'd0}, '{6'd8, 6'd0, 6'd0, 6'd0},
		'{6'd8, 6'd9, 6'd0, 6'd0}, '{6'd10, 6'd0, 6'd0, 6'd0},
		'{6'd10, 6'd11, 6'd0, 6'd0}, '{6'd12, 6'd0, 6'd0, 6'd0},
		'{6'd13, 6'd0, 6'd0, 6'd0}, '{6'd14, 6'd0, 6'd0, 6'd0},
		'{6'd14, 6'd15, 6'd0, 6'd0}, '{6'd16, 6'd0, 6'd0, 6'd0},
		'{6'd17, 6'd0, 6'd0, 6'd0}, '{6'd18, 6'd0, 6'd0, 6'd0},
		'{6'd18, 6'd19, 6'd0, 6'd0}, '{6'd20, 6'd0, 6'd0, 6'd0},
		'{6'd21, 6'd0, 6'd0, 6'd0}, '{6'd21, 6'd22, 6'd0, 6'd0},
		'{6'd23, 6'd0, 6'd0, 6'd0}, '{6'd24, 6'd0, 6'd0, 6'd0},
		'{6'd25, 6'd0, 6'd0, 6'd0}, '{6'd26, 6'd0, 6'd0, 6'd0},
		'{6'd27, 6'd30, 6'd0, 6'd0}, '{6'd28, 6'd0, 6'd0, 6'd0},
		'{6'd29, 6'd0, 6'd0, 6'd0}, '{6'd30, 6'd0, 6'd0, 6'd0},
		'{6'd30, 6'd31, 6'd33, 6'd0}, '{6'd31, 6'd32, 6'd0, 6'd0},
		'{6'd32, 6'd33, 6'd0, 6'd0}, '{6'd34, 6'd0, 6'd0, 6'd0},
		'{6'd35, 6'd0, 6'd0, 6'd0}, '{6'd36, 6'd0, 6'd0, 6'd0},
		'{6'd0, 6'd0, 6'd0, 6'd0}, '{6'd37, 6'd38, 6'd0, 6'd0},
		'{6'd38, 6'd39, 6'd0, 6'd0}, '{6'd40, 6'd0, 6'd0, 6'd0},
		'{6'd41, 6'd0, 6'd0, 6'd0}, '{6'd42, 6'd0, 6'd0, 6'd0},
		'{6'd43, 6'd0, 6'd0, 6'd0}, '{6'd43, 6'd44, 6'd45, 6'd0},
		'{6'd45, 6'd0, 6'd0, 6'd0}, '{6'd46, 6'd0, 6'd0, 6'd0},
		'{6'd46, 6'd47, 6'd0, 6'd0}, '{6'd48, 6'd0, 6'd0, 6'd0},
		'{6'd49, 6'd0, 6'd0, 6'd0}, '{6'd50, 6'd0, 6'd0, 6'd0},
		'{6'd50, 6'd51, 6'd0, 6'd0}, '{6'd52, 6'd0, 6'd0, 6'd0},
		'{6'd53, 6'd0, 6'd0, 6'd0}, '{6'd54, 6'd0, 6'd0, 6'd0},
		'{6'd55, 6'd0, 6'd0, 6'd0}, '{6'd55, 6'd56, 6'd0, 6'd0},
		'{6'd57, 6'd0, 6'd0, 6'd0}, '{6'd58, 6'd0, 6'd0, 6'd0},
		'{6'd59, 6'd0, 6'd0, 6'd0}, '{6'd60, 6'd0, 6'd0, 6'd0},
		'{6'd0, 6'd0, 6'd0, 6'd0}
	};

	localparam logic [7:0] FROM_WORD [5] = '{8'h46, 8'h72, 8'h6F, 8'h6D, 8'h20};

	// Whether a byte belongs to a character class.
	function automatic logic class_match(char_class_t cls, logic [7:0] b);
		logic alpha;
		logic digit;
		logic res;
		alpha = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
		digit = b >= 8'h30 && b <= 8'h39;
		case (cls)
			CL_F: res = b == 8'h46;
			CL_R: res = b == 8'h72;
			CL_O: res = b == 8'h6F;
			CL_M: res = b == 8'h6D;
			CL_SP: res = b == 8'h20;
			CL_NSP: res = b != 8'h20;
			CL_DQ: res = b == 8'h22;
			CL_NDQ: res = b != 8'h22;
			CL_AL: res = alpha;
			CL_D03S: res = b == 8'h20 || (b >= 8'h30 && b <= 8'h33);
			CL_DIG: res = digit;
			CL_D02: res = b >= 8'h30 && b <= 8'h32;
			CL_COLON: res = b == 8'h3A;
			CL_D05: res = b >= 8'h30 && b <= 8'h35;
			CL_D12: res = b == 8'h31 || b == 8'h32;
			CL_D03: res = b >= 8'h30 && b <= 8'h33;
			CL_COMMA: res = b == 8'h2C;
			default: res = 1'b0;
		endcase
		return res;
	endfunction

	// One step of the pattern matcher: every active position enables its successors.
	function automatic nfa_vec_t nfa_step(nfa_vec_t cur, logic [7:0] b);
		nfa_vec_t nx;
		logic [5:0] q;
		nx = '0;
		for (int p = 0; p < NFA_POS; p++) begin
			for (int k = 0; k < NFA_FANOUT; k++) begin
				q = POS_NEXT[p][k];
				if (cur[p] && q != 6'd0 && class_match(POS_CLASS[q], b)) begin
					nx[q] = 1'b1;
				end
			end
		end
		return nx;
	endfunction

endpackage

>>> hdl/mbox_message_splitter.sv
`timescale 1ns / 1ps

// Mailbox splitter: takes one byte of an mbox file per request on the input
// channel (in_valid / in_stall) and returns one result per newline and per
// end-of-file marker on the output channel (out_valid / out_stall). Bytes
// that are not newlines produce no result.
// A request is registered on acceptance; the state update then advances the
// line and message state and loads the result register, unless the receiver
// stalls. One byte is taken every cycle while the receiver does not stall;
// the state update between the two registers is combinational.
// When the receiver stalls, the result is held, the state update pauses and
// the input register takes at most one more request; in_stall is then high
// until the waiting result is taken.
// Configuration is written through cfg_we / cfg_index / cfg_data only while
// the block is idle: a rule for the user, which the block does not enforce.
// Reset clears all line and message state, sets the register defaults
// (target 0, quirk mode off, 100 MiB limit) and empties both registers. An
// end-of-file request also resets the state but keeps the configuration.
module mbox_message_splitter
	import mbox_pkg::*;
#(
	parameter int LINE_LEN_BITS = 16,
	parameter int MSG_NUM_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] data_byte,
	input  logic end_of_file,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] line_kind,
	output logic [MSG_NUM_BITS-1:0] message_number,
	output logic [LINE_LEN_BITS-1:0] line_length,
	output logic keep,
	output logic oversize
);

	localparam int CMP_BITS = 32;

	// Configuration registers.
	logic [TARGET_BITS-1:0] target_q;
	logic quirk_q;
	logic [MIB_BITS-1:0] max_mib_q;

	// Input register.
	logic s1_valid_s1;
	logic [7:0] byte_s1;
	logic eof_s1;

	// Line and message state.
	nfa_vec_t nfa_q, nfa_d;
	logic hit_q, hit_d;
	logic [2:0] short_q, short_d;
	logic blank_q, blank_d;
	logic [LINE_LEN_BITS-1:0] raw_q, raw_d, trim_q, trim_d;
	logic [MSG_NUM_BITS-1:0] msg_q, msg_d;
	logic [BYTES_BITS-1:0] bytes_q, bytes_d;

	// Result register.
	logic out_valid_q;
	logic res_en;
	logic [1:0] kind_d, kind_q;
	logic [MSG_NUM_BITS-1:0] num_q;
	logic [LINE_LEN_BITS-1:0] len_d, len_q;
	logic keep_d, keep_q, over_d, over_q;

	logic out_free, step;
	nfa_vec_t nfa_adv;
	logic sep, keep_line;
	logic [BYTES_BITS:0] bytes_sum;
	logic [BYTES_BITS-1:0] limit;

	assign out_free = !out_valid_q || !out_stall;
	assign step = s1_valid_s1 && out_free;
	assign in_stall = s1_valid_s1 && !out_free;
	assign limit = BYTES_BITS'({max_mib_q, MIB_SHIFT'(0)});
	assign nfa_adv = nfa_step(nfa_q, byte_s1);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			quirk_q <= 1'b0;
			max_mib_q <= MAX_MIB_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET: target_q <= cfg_data[TARGET_BITS-1:0];
				REG_QUIRK: quirk_q <= cfg_data[0];
				REG_MAX_MIB: max_mib_q <= cfg_data[MIB_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			eof_s1 <= end_of_file;
		end
	end

	// Next state and result for the registered byte.
	always_comb begin
		nfa_d = nfa_q;
		hit_d = hit_q;
		short_d = short_q;
		blank_d = blank_q;
		raw_d = raw_q;
		trim_d = trim_q;
		msg_d = msg_q;
		bytes_d = bytes_q;
		res_en = 1'b0;
		kind_d = KIND_BODY;
		len_d = '0;
		keep_d = 1'b0;
		over_d = 1'b0;
		sep = 1'b0;
		keep_line = CMP_BITS'(target_q) == 0 || CMP_BITS'(msg_q) == CMP_BITS'(target_q);
		bytes_sum = (BYTES_BITS + 1)'(bytes_q) + (BYTES_BITS + 1)'(trim_q) + 1'b1;
		if (eof_s1) begin
			res_en = 1'b1;
			kind_d = KIND_EOF;
			over_d = bytes_q > limit;
			nfa_d = nfa_vec_t'(1);
			hit_d = 1'b0;
			short_d = '0;
			raw_d = '0;
			trim_d = '0;
			blank_d = 1'b1;
			msg_d = '0;
			bytes_d = '0;
		end else if (byte_s1 != CH_LF) begin
			if (raw_q != '1) begin
				raw_d = raw_q + 1'b1;
			end
			if (byte_s1 != CH_CR) begin
				trim_d = raw_d;
			end
			nfa_d = nfa_adv;
			hit_d = hit_q || nfa_adv[ACC_A] || nfa_adv[ACC_B];
			if (short_q < SHORT_DONE) begin
				short_d = (byte_s1 == FROM_WORD[short_q]) ? short_q + 1'b1 : SHORT_FAIL;
			end else if (short_q == SHORT_DONE && byte_s1 != CH_CR) begin
				short_d = SHORT_FAIL;
			end
		end else begin
			// End of line: decide separator, then tag the line.
			res_en = 1'b1;
			len_d = trim_q;
			if (blank_q) begin
				if (trim_q != '0) begin
					if (!quirk_q) begin
						blank_d = 1'b0;
					end
					sep = hit_q || (quirk_q && short_q == SHORT_DONE);
				end
			end else if (trim_q == '0) begin
				blank_d = 1'b1;
			end
			if (sep) begin
				if (msg_q != '1) begin
					msg_d = msg_q + 1'b1;
				end
				bytes_d = '0;
				kind_d = KIND_SEP;
			end else begin
				if (keep_line) begin
					bytes_d = bytes_sum[BYTES_BITS] ? '1 : bytes_sum[BYTES_BITS-1:0];
				end
				kind_d = KIND_BODY;
				keep_d = keep_line;
				over_d = bytes_d > limit;
			end
			nfa_d = nfa_vec_t'(1);
			hit_d = 1'b0;
			short_d = '0;
			raw_d = '0;
			trim_d = '0;
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nfa_q <= nfa_vec_t'(1);
			hit_q <= 1'b0;
			short_q <= '0;
			blank_q <= 1'b1;
			raw_q <= '0;
			trim_q <= '0;
			msg_q <= '0;
			bytes_q <= '0;
		end else if (step) begin
			nfa_q <= nfa_d;
			hit_q <= hit_d;
			short_q <= short_d;
			blank_q <= blank_d;
			raw_q <= raw_d;
			trim_q <= trim_d;
			msg_q <= msg_d;
			bytes_q <= bytes_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step && res_en;
		end
	end

	// At end of file the result names the last message, not the cleared count.
	always_ff @(posedge clk) begin
		if (out_free && step && res_en) begin
			kind_q <= kind_d;
			num_q <= eof_s1 ? msg_q : msg_d;
			len_q <= len_d;
			keep_q <= keep_d;
			over_q <= over_d;
		end
	end

	assign out_valid = out_valid_q;
	assign line_kind = kind_q;
	assign message_number = num_q;
	assign line_length = len_q;
	assign keep = keep_q;
	assign oversize = over_q;

	// A separator result never carries keep or oversize.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_kind == KIND_SEP |-> !keep && !oversize)
		else $error("separator result with keep or oversize");

	// An end-of-file result has no length and is not kept.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_kind == KIND_EOF |-> line_length == '0 && !keep)
		else $error("end-of-file result with length or keep");

	// The input side only stalls while the input register holds a request.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_s1 && out_valid_q)
		else $error("input stalled without a pending request");

	// After an end-of-file step the message state is back at reset.
	assert property (@(posedge clk) disable iff (!arst_n)
		step && eof_s1 |=> msg_q == '0 && bytes_q == '0 && blank_q)
		else $error("state not cleared after end of file");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb
	import mbox_pkg::*;
();

	typedef struct {
		logic [1:0] kind;
		logic [23:0] number;
		logic [15:0] length;
		logic kept;
		logic over;
	} line_result_t;

	// Tracks the splitter's line and message state and the results still owed.
	class splitter_scoreboard;
		logic [23:0] target;
		logic quirk;
		logic [11:0] max_mib;
		logic [NFA_POS-1:0] nfa;
		logic hit;
		logic [2:0] short_pos;
		logic after_blank;
		logic [15:0] raw_len;
		logic [15:0] trim_len;
		logic [23:0] cur_msg;
		logic [32:0] msg_bytes;
		line_result_t pending[$];
		int errors;

		function new();
			target = '0;
			quirk = 1'b0;
			max_mib = MAX_MIB_RESET;
			errors = 0;
			clear_file();
		endfunction

		function void clear_line();
			nfa = NFA_POS'(1);
			hit = 1'b0;
			short_pos = '0;
			raw_len = '0;
			trim_len = '0;
		endfunction

		function void clear_file();
			clear_line();
			after_blank = 1'b1;
			cur_msg = '0;
			msg_bytes = '0;
		endfunction

		function logic over_limit();
			return msg_bytes > {1'b0, max_mib, 20'd0};
		endfunction

		function logic in_class(char_class_t c, logic [7:0] b);
			logic letter;
			letter = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
			case (c)
				CL_F: return b == "F";
				CL_R: return b == "r";
				CL_O: return b == "o";
				CL_M: return b == "m";
				CL_SP: return b == " ";
				CL_NSP: return b != " ";
				CL_DQ: return b == 8'h22;
				CL_NDQ: return b != 8'h22;
				CL_AL: return letter;
				CL_D03S: return b == " " || (b >= "0" && b <= "3");
				CL_DIG: return b >= "0" && b <= "9";
				CL_D02: return b >= "0" && b <= "2";
				CL_COLON: return b == ":";
				CL_D05: return b >= "0" && b <= "5";
				CL_D12: return b == "1" || b == "2";
				CL_D03: return b >= "0" && b <= "3";
				CL_COMMA: return b == ",";
				default: return 1'b0;
			endcase
		endfunction

		function void config_write(logic [1:0] idx, logic [23:0] val);
			case (idx)
				REG_TARGET: target = val;
				REG_QUIRK: quirk = val[0];
				REG_MAX_MIB: max_mib = val[11:0];
				default: ;
			endcase
		endfunction

		// Called for every accepted request.
		function void note_request(logic [7:0] b, logic eof);
			line_result_t r;
			logic [NFA_POS-1:0] nx;
			logic [5:0] q;
			logic [15:0] ll;
			logic sep;
			logic [33:0] sum;
			if (eof) begin
				r = '{KIND_EOF, cur_msg, 16'd0, 1'b0, over_limit()};
				pending = {pending, r};
				clear_file();
				return;
			end
			if (b != CH_LF) begin
				if (raw_len != 16'hFFFF)
					raw_len++;
				if (b != CH_CR)
					trim_len = raw_len;
				nx = '0;
				for (int p = 0; p < NFA_POS; p++)
					for (int k = 0; k < NFA_FANOUT; k++) begin
						q = POS_NEXT[p][k];
						if (nfa[p] && q != 0 && in_class(POS_CLASS[q], b))
							nx[q] = 1'b1;
					end
				nfa = nx;
				if (nx[ACC_A] || nx[ACC_B])
					hit = 1'b1;
				if (short_pos < SHORT_DONE)
					short_pos = (b == FROM_WORD[short_pos]) ? short_pos + 3'd1 : SHORT_FAIL;
				else if (short_pos == SHORT_DONE && b != CH_CR)
					short_pos = SHORT_FAIL;
				return;
			end
			// A newline finishes the line.
			ll = trim_len;
			sep = 1'b0;
			if (after_blank) begin
				if (ll != 0) begin
					if (!quirk)
						after_blank = 1'b0;
					if (hit || (quirk && short_pos == SHORT_DONE))
						sep = 1'b1;
				end
			end else if (ll == 0) begin
				after_blank = 1'b1;
			end
			if (sep) begin
				if (cur_msg != 24'hFFFFFF)
					cur_msg++;
				msg_bytes = '0;
				r = '{KIND_SEP, cur_msg, ll, 1'b0, 1'b0};
			end else begin
				r.kept = target == 0 || cur_msg == target;
				if (r.kept) begin
					sum = msg_bytes + ll + 34'd1;
					msg_bytes = sum[33] ? '1 : sum[32:0];
				end
				r.kind = KIND_BODY;
				r.number = cur_msg;
				r.length = ll;
				r.over = over_limit();
			end
			pending = {pending, r};
			clear_line();
		endfunction

		function void check_result(logic [1:0] kind, logic [23:0] number, logic [15:0] length,
				logic kept, logic over);
			line_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result: kind %0d, message %0d", kind, number);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (kind !== e.kind) begin
				$error("line_kind: expected %0d, actual %0d", e.kind, kind);
				errors++;
			end
			if (number !== e.number) begin
				$error("message_number: expected %0d, actual %0d", e.number, number);
				errors++;
			end
			if (length !== e.length) begin
				$error("line_length: expected %0d, actual %0d", e.length, length);
				errors++;
			end
			if (kept !== e.kept) begin
				$error("keep: expected %0d, actual %0d", e.kept, kept);
				errors++;
			end
			if (over !== e.over) begin
				$error("oversize: expected %0d, actual %0d", e.over, over);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] data_byte = '0;
	logic end_of_file = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] line_kind;
	logic [23:0] message_number;
	logic [15:0] line_length;
	logic keep;
	logic oversize;

	splitter_scoreboard sb = new();
	int idle_in = 0;
	int idle_out = 0;
	int sent = 0;
	logic [7:0] line_buf[$];

	mbox_message_splitter i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .end_of_file(end_of_file),
		.out_valid(out_valid), .out_stall(out_stall),
		.line_kind(line_kind), .message_number(message_number),
		.line_length(line_length), .keep(keep), .oversize(oversize)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver stalls at random; results are checked at the negative edge,
	// where both valid and stall are settled for the coming rising edge.
	always @(posedge clk) begin
		if (arst_n)
			out_stall <= $urandom_range(99) < idle_out;
	end

	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(line_kind, message_number, line_length, keep, oversize);
	end

	// Offer one request and wait until it is taken.
	task automatic send(logic [7:0] b, logic eof);
		while ($urandom_range(99) < idle_in) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_file <= eof;
		forever begin
			@(negedge clk);
			if (!in_stall)
				break;
			@(posedge clk);
		end
		@(posedge clk);
		sb.note_request(b, eof);
		sent++;
	endtask

	task automatic add_byte(logic [7:0] b);
		line_buf = {line_buf, b};
	endtask

	task automatic put_str(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic send_buf();
		foreach (line_buf[i])
			send(line_buf[i], 1'b0);
		line_buf.delete();
	endtask

	task automatic send_line(string s);
		put_str(s);
		add_byte(CH_LF);
		send_buf();
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.config_write(idx, val);
	endtask

	task automatic set_config(logic [23:0] tgt, logic qk, logic [11:0] mib);
		write_reg(REG_TARGET, tgt);
		write_reg(REG_QUIRK, {23'd0, qk});
		write_reg(REG_MAX_MIB, {12'd0, mib});
	endtask

	task automatic put_letters(int n);
		for (int i = 0; i < n; i++)
			add_byte($urandom_range(1) ? 8'($urandom_range("a", "z"))
				: 8'($urandom_range("A", "Z")));
	endtask

	task automatic put_spaces();
		if ($urandom_range(3) == 0)
			put_str("  ");
		else
			put_str(" ");
	endtask

	// Build a separator-shaped line in either date layout, now and then broken.
	task automatic build_from_line();
		int n;
		put_str("From");
		put_spaces();
		if ($urandom_range(3) == 0) begin
			add_byte(8'h22);
			put_str("a b");
			add_byte(8'h22);
		end else begin
			n = $urandom_range(1, 6);
			repeat (n) add_byte(8'($urandom_range(33, 126)));
		end
		put_spaces();
		put_letters(3);
		if ($urandom_range(1)) begin
			put_spaces(); put_letters(3); put_spaces();
			put_str($urandom_range(1) ? $sformatf("%2d", $urandom_range(1, 9))
				: $sformatf("%0d", $urandom_range(10, 31)));
			put_spaces();
			put_str($sformatf("%02d:%02d", $urandom_range(23), $urandom_range(59)));
			if ($urandom_range(1))
				put_str($sformatf(":%02d", $urandom_range(59)));
			put_spaces();
			if ($urandom_range(2) == 0) begin
				put_str("+0100");
				put_spaces();
			end
			put_str($sformatf("%0d", $urandom_range(1000, 2999)));
		end else begin
			put_str(",");
			put_spaces();
			put_str($sformatf("%0d", $urandom_range(0, 39)));
			put_spaces(); put_letters(3); put_spaces();
			put_str($sformatf("%0d", $urandom_range(1000, 2999)));
			put_spaces();
			put_str($sformatf("%02d:%02d", $urandom_range(29), $urandom_range(59)));
		end
		if ($urandom_range(4) == 0)
			put_str(" tail");
		if ($urandom_range(4) == 0)
			line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(0, 9));
		if ($urandom_range(5) == 0)
			add_byte(CH_CR);
	endtask

	// Random file: mostly well-formed messages, with noise and broken lines.
	task automatic random_file(int bytes);
		int start;
		int n;
		start = sent;
		while (sent - start < bytes) begin
			case ($urandom_range(19))
				0, 1, 2, 3: begin
					add_byte(CH_LF);
					build_from_line();
				end
				4, 5, 6, 7: ;
				8: put_str("From ");
				9: build_from_line();
				default: begin
					n = $urandom_range(0, 12);
					repeat (n) add_byte(8'($urandom_range(255)));
					foreach (line_buf[i])
						if (line_buf[i] == CH_LF)
							line_buf[i] = CH_CR;
				end
			endcase
			if ($urandom_range(3) == 0)
				add_byte(CH_CR);
			add_byte(CH_LF);
			send_buf();
			if ($urandom_range(60) == 0)
				send(8'($urandom_range(255)), 1'b1);
		end
		if ($urandom_range(1))
			put_str("unterminated");
		send_buf();
		send(8'($urandom_range(255)), 1'b1);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_in = 27;
		idle_out = 59;

		// Directed part at the reset settings.
		send_line("before any message");
		send_line("");
		send_line("From a@b Mon Jan  5 12:34:56 2024");
		send(8'h00, 1'b0); send(8'hFF, 1'b0); send(CH_LF, 1'b0);
		send_line("From x Tue, 5 Jan 2024 23:59");
		send_line("");
		send_line("From \r\r");
		send_line("\r");
		put_str("dropped line");
		send_buf();
		send(8'h00, 1'b1);
		drain();

		// Quirk mode, zero limit, target one; a line of a single CR counts as blank.
		set_config(24'd1, 1'b1, 12'd0);
		send_line("From \r");
		send_line("body of message one");
		send_line("From \"q q\" Wed Feb 29 01:02 +0000 1999");
		send_line("From z Thu Mar 31 09:09:09 2000 extra");
		add_byte(CH_CR);
		send_line("");
		send(8'h00, 1'b1);
		drain();

		set_config(24'hFFFFFF, 1'b0, 12'd4095);
		random_file(320);
		drain();
		set_config(24'd2, 1'b1, 12'd100);
		random_file(320);
		drain();

		idle_in = 59;
		idle_out = 27;
		set_config(24'd0, 1'b0, 12'd0);
		random_file(300);
		// Hold the sender back until every result has come.
		drain();
		set_config(24'd1, 1'b0, 12'd1);
		random_file(300);
		drain();

		idle_in = 0;
		idle_out = 0;
		set_config(24'd3, 1'b1, 12'd4095);
		random_file(300);
		drain();
		set_config(24'd0, 1'b1, 12'd0);
		random_file(200);
		drain();
		repeat (10) @(posedge clk);

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Run limit.
	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

endmodule
